@@ hdl/mwhp_pkg.sv @@
// ============================================================================
// mwhp_pkg - shared definitions for the masked weighted histogram peak core
// Holds default sizes, input mode codes, the internal command codes and the
// status bundle passed from the back end to the rest of the block.
// ============================================================================
package mwhp_pkg;

    // Default configuration of the core
    localparam int BIN_COUNT_DEF   = 65536;
    localparam int PIXEL_WIDTH_DEF = 18;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths
    localparam int LABEL_W  = 8;
    localparam int MODE_W   = 2;
    localparam int RBIN_W   = 16;
    localparam int PBIN_W   = 16;
    localparam int PWGT_W   = 31;
    localparam int WGT_W    = 32;
    localparam int WIDE_W   = 34;
    localparam int SUM_W    = 33;

    localparam logic [LABEL_W-1:0] TARGET_LABEL_RST = 8'd1;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Internal command codes after classification
    typedef enum logic [1:0] {
        OP_NOP,
        OP_ACC,
        OP_READ,
        OP_CLEAR
    } op_t;

    localparam int OP_W = 2;

    // Status of the back end
    typedef struct packed {
        logic init_clear;
        logic clearing;
        logic popping;
    } status_t;

endpackage

@@ hdl/mwhp_in_if.sv @@
// ============================================================================
// mwhp_in_if - pixel command channel
// Valid/ready channel carrying one pixel command per transfer.
// ============================================================================
interface mwhp_in_if #(
    parameter int PIXEL_WIDTH = mwhp_pkg::PIXEL_WIDTH_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic [mwhp_pkg::MODE_W-1:0]       mode;
    logic signed [PIXEL_WIDTH-1:0]     pixel_value;
    logic [mwhp_pkg::LABEL_W-1:0]      seg_label;
    logic [mwhp_pkg::RBIN_W-1:0]       read_bin;

    modport source (output valid, output mode, output pixel_value, output seg_label,
                    output read_bin, input ready);
    modport sink   (input valid, input mode, input pixel_value, input seg_label,
                    input read_bin, output ready);
endinterface

@@ hdl/mwhp_out_if.sv @@
// ============================================================================
// mwhp_out_if - result channel
// Valid/ready channel carrying one result per transfer.
// ============================================================================
interface mwhp_out_if ();
    logic                               valid;
    logic                               ready;
    logic [mwhp_pkg::PBIN_W-1:0]        peak_bin;
    logic [mwhp_pkg::PWGT_W-1:0]        peak_weight;
    logic signed [mwhp_pkg::WGT_W-1:0]  bin_weight;
    logic                               saturated;

    modport source (output valid, output peak_bin, output peak_weight, output bin_weight,
                    output saturated, input ready);
    modport sink   (input valid, input peak_bin, input peak_weight, input bin_weight,
                    input saturated, output ready);
endinterface

@@ hdl/mwhp_front.sv @@
// ============================================================================
// mwhp_front - command classifier
// Holds the target label, accepts pixel commands and turns each into an
// internal command with a resolved bin address.
// ============================================================================
module mwhp_front #(
    parameter int BIN_COUNT   = mwhp_pkg::BIN_COUNT_DEF,
    parameter int PIXEL_WIDTH = mwhp_pkg::PIXEL_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mwhp_pkg::LABEL_W-1:0]   cfg_data,
    input  mwhp_pkg::status_t              status,
    mwhp_in_if.sink                        in_ch,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [mwhp_pkg::OP_W+$clog2(BIN_COUNT)+PIXEL_WIDTH-1:0] push_data
);

    localparam int BIN_W = $clog2(BIN_COUNT);

    logic [mwhp_pkg::LABEL_W-1:0] target_label_reg;
    logic [mwhp_pkg::WIDE_W-1:0]  pix_ext;
    logic [BIN_W-1:0]             clamp_bin;
    logic                         rbin_in_range;
    mwhp_pkg::op_t                op;
    logic [BIN_W-1:0]             addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_label_reg <= mwhp_pkg::TARGET_LABEL_RST;
        end
        else if (cfg_we)
        begin
            target_label_reg <= cfg_data;
        end
    end

    assign pix_ext = {{(mwhp_pkg::WIDE_W-PIXEL_WIDTH){in_ch.pixel_value[PIXEL_WIDTH-1]}},
                      in_ch.pixel_value};

    // Negative values go to the first bin, large ones to the last
    always_comb
    begin
        if (pix_ext[mwhp_pkg::WIDE_W-1])
        begin
            clamp_bin = '0;
        end
        else if (pix_ext > mwhp_pkg::WIDE_W'(BIN_COUNT - 1))
        begin
            clamp_bin = BIN_W'(BIN_COUNT - 1);
        end
        else
        begin
            clamp_bin = pix_ext[BIN_W-1:0];
        end
    end

    assign rbin_in_range = (17'(in_ch.read_bin) < 17'(BIN_COUNT));

    always_comb
    begin
        op   = mwhp_pkg::OP_NOP;
        addr = clamp_bin;
        case (in_ch.mode)
            mwhp_pkg::MODE_ACC:
            begin
                if (in_ch.seg_label == target_label_reg)
                begin
                    op = mwhp_pkg::OP_ACC;
                end
            end
            mwhp_pkg::MODE_READ:
            begin
                addr = in_ch.read_bin[BIN_W-1:0];
                if (rbin_in_range)
                begin
                    op = mwhp_pkg::OP_READ;
                end
            end
            mwhp_pkg::MODE_CLEAR:
            begin
                op = mwhp_pkg::OP_CLEAR;
            end
            default:
            begin
                op = mwhp_pkg::OP_NOP;
            end
        endcase
    end

    // Hold off transfers until the start-up sweep has cleared the bins
    assign in_ch.ready = push_ready && !status.init_clear;
    assign push_valid  = in_ch.valid && !status.init_clear;
    assign push_data   = {op, addr, in_ch.pixel_value};

endmodule

@@ hdl/mwhp_queue.sv @@
// ============================================================================
// mwhp_queue - command queue
// Small first-in first-out buffer between the classifier and the back end.
// ============================================================================
module mwhp_queue #(
    parameter int DEPTH  = mwhp_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/mwhp_back.sv @@
// ============================================================================
// mwhp_back - histogram engine
// Owns the bin memory and the running peak, executes queued commands and
// drives the registered result channel.
// ============================================================================
module mwhp_back #(
    parameter int BIN_COUNT   = mwhp_pkg::BIN_COUNT_DEF,
    parameter int PIXEL_WIDTH = mwhp_pkg::PIXEL_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [mwhp_pkg::OP_W+$clog2(BIN_COUNT)+PIXEL_WIDTH-1:0] pop_data,
    output mwhp_pkg::status_t              status,
    mwhp_out_if.source                     out_ch
);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int CMD_W = mwhp_pkg::OP_W + BIN_W + PIXEL_WIDTH;
    localparam int SUM_W = mwhp_pkg::SUM_W;
    localparam int WGT_W = mwhp_pkg::WGT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_ACC_RD,
        S_ACC_WR
    } state_t;

    state_t                      state_reg;
    logic [BIN_W-1:0]            ptr_reg;
    logic                        clr_out_reg;
    logic                        init_reg;
    logic [BIN_W-1:0]            addr_reg;
    logic [PIXEL_WIDTH-1:0]      value_reg;
    logic [WGT_W-1:0]            sum_reg;
    logic                        sat_reg;
    logic [BIN_W-1:0]            peak_idx_reg;
    logic [mwhp_pkg::PWGT_W-1:0] peak_w_reg;
    logic                        out_valid_reg;
    logic [mwhp_pkg::PBIN_W-1:0] out_peak_bin_reg;
    logic [mwhp_pkg::PWGT_W-1:0] out_peak_w_reg;
    logic [WGT_W-1:0]            out_bin_w_reg;
    logic                        out_sat_reg;

    logic [WGT_W-1:0]            mem [BIN_COUNT];
    logic [WGT_W-1:0]            rdata_reg;

    mwhp_pkg::op_t               pop_op;
    logic [BIN_W-1:0]            pop_addr;
    logic [PIXEL_WIDTH-1:0]      pop_value;
    logic                        popping;
    logic                        rd_en;
    logic                        wr_en;
    logic [BIN_W-1:0]            wr_addr;
    logic [WGT_W-1:0]            wr_data;
    logic [SUM_W-1:0]            sum_raw;
    logic                        sum_sat;
    logic [WGT_W-1:0]            sum_clip;
    logic                        peak_hit;

    assign pop_op    = mwhp_pkg::op_t'(pop_data[CMD_W-1 -: mwhp_pkg::OP_W]);
    assign pop_addr  = pop_data[PIXEL_WIDTH +: BIN_W];
    assign pop_value = pop_data[PIXEL_WIDTH-1:0];
    assign pop_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign popping   = pop_valid && pop_ready;
    assign rd_en     = popping && ((pop_op == mwhp_pkg::OP_ACC) || (pop_op == mwhp_pkg::OP_READ));

    assign wr_en   = (state_reg == S_CLEAR) || (state_reg == S_ACC_WR);
    assign wr_addr = (state_reg == S_CLEAR) ? ptr_reg : addr_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : sum_reg;

    // Add the signed pixel and clip to the 32-bit signed range
    assign sum_raw  = {rdata_reg[WGT_W-1], rdata_reg}
                    + {{(SUM_W-PIXEL_WIDTH){value_reg[PIXEL_WIDTH-1]}}, value_reg};
    assign sum_sat  = (sum_raw[SUM_W-1] != sum_raw[SUM_W-2]);
    assign sum_clip = !sum_sat ? sum_raw[WGT_W-1:0]
                    : (sum_raw[SUM_W-1] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}});

    assign peak_hit = !sum_reg[WGT_W-1] && (sum_reg[WGT_W-2:0] > peak_w_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[pop_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            clr_out_reg   <= 1'b0;
            init_reg      <= 1'b1;
            peak_idx_reg  <= '0;
            peak_w_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (popping)
                    begin
                        addr_reg  <= pop_addr;
                        value_reg <= pop_value;
                        case (pop_op)
                            mwhp_pkg::OP_ACC:
                            begin
                                state_reg <= S_ACC_RD;
                            end
                            mwhp_pkg::OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            mwhp_pkg::OP_CLEAR:
                            begin
                                ptr_reg      <= '0;
                                clr_out_reg  <= 1'b1;
                                peak_idx_reg <= '0;
                                peak_w_reg   <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            default:
                            begin
                                out_peak_bin_reg <= mwhp_pkg::PBIN_W'(peak_idx_reg);
                                out_peak_w_reg   <= peak_w_reg;
                                out_bin_w_reg    <= '0;
                                out_sat_reg      <= 1'b0;
                                out_valid_reg    <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    out_peak_bin_reg <= mwhp_pkg::PBIN_W'(peak_idx_reg);
                    out_peak_w_reg   <= peak_w_reg;
                    out_bin_w_reg    <= rdata_reg;
                    out_sat_reg      <= 1'b0;
                    out_valid_reg    <= 1'b1;
                    state_reg        <= S_IDLE;
                end
                S_ACC_RD:
                begin
                    sum_reg   <= sum_clip;
                    sat_reg   <= sum_sat;
                    state_reg <= S_ACC_WR;
                end
                S_ACC_WR:
                begin
                    if (peak_hit)
                    begin
                        peak_idx_reg     <= addr_reg;
                        peak_w_reg       <= sum_reg[WGT_W-2:0];
                        out_peak_bin_reg <= mwhp_pkg::PBIN_W'(addr_reg);
                        out_peak_w_reg   <= sum_reg[WGT_W-2:0];
                    end
                    else
                    begin
                        out_peak_bin_reg <= mwhp_pkg::PBIN_W'(peak_idx_reg);
                        out_peak_w_reg   <= peak_w_reg;
                    end
                    out_bin_w_reg <= '0;
                    out_sat_reg   <= sat_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == BIN_W'(BIN_COUNT - 1))
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                        if (clr_out_reg)
                        begin
                            clr_out_reg      <= 1'b0;
                            out_peak_bin_reg <= '0;
                            out_peak_w_reg   <= '0;
                            out_bin_w_reg    <= '0;
                            out_sat_reg      <= 1'b0;
                            out_valid_reg    <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign status.init_clear = init_reg;
    assign status.clearing   = (state_reg == S_CLEAR);
    assign status.popping    = popping;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.peak_bin    = out_peak_bin_reg;
    assign out_ch.peak_weight = out_peak_w_reg;
    assign out_ch.bin_weight  = out_bin_w_reg;
    assign out_ch.saturated   = out_sat_reg;

endmodule

@@ hdl/masked_weighted_histogram_peak_core.sv @@
// ============================================================================
// masked_weighted_histogram_peak_core - masked intensity histogram with peak
// Top level: classifier, command queue and histogram engine.
// ============================================================================
// Pixels whose label matches target_label add their signed intensity to the
// bin picked by the clamped value; a running peak follows the heaviest bin.
// Each transfer on in_ch gives exactly one transfer on out_ch. Commands are
// classified on entry and wait in a short queue, so in_ch keeps taking up to
// QUEUE_DEPTH transfers while a result waits on out_ch. The engine works one
// command at a time around a single-port bin memory with registered read
// data: an ignored pixel or unused mode reports straight from the idle
// state, a bin read reads the memory and then reports, and an accumulate
// runs memory read, add with clipping, then write-back with peak compare.
// The engine takes the next command only once out_ch has taken the result.
// A clear walks the memory one bin per cycle and then reports. After reset
// the same walk runs with in_ch.ready held low; target_label may be written
// during it.
// ============================================================================
module masked_weighted_histogram_peak_core #(
    parameter int BIN_COUNT   = mwhp_pkg::BIN_COUNT_DEF,
    parameter int PIXEL_WIDTH = mwhp_pkg::PIXEL_WIDTH_DEF,
    parameter int QUEUE_DEPTH = mwhp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mwhp_pkg::LABEL_W-1:0] cfg_data,
    mwhp_in_if.sink                      in_ch,
    mwhp_out_if.source                   out_ch
);

    localparam int CMD_W = mwhp_pkg::OP_W + $clog2(BIN_COUNT) + PIXEL_WIDTH;

    logic              push_valid;
    logic              push_ready;
    logic [CMD_W-1:0]  push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [CMD_W-1:0]  pop_data;
    mwhp_pkg::status_t status;

    // Classify each transfer: turn label mismatches into no-ops, resolve the
    // bin address
    mwhp_front #(
        .BIN_COUNT   (BIN_COUNT),
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .status     (status),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the classifier from the engine
    mwhp_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Execute commands against the bin memory and track the peak
    mwhp_back #(
        .BIN_COUNT   (BIN_COUNT),
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .status    (status),
        .out_ch    (out_ch)
    );

    // No command may leave the queue while the memory is being swept
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !status.popping)
        else $error("command taken during clear sweep");

    // No result is presented during a sweep
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !out_ch.valid)
        else $error("result valid during clear sweep");

    // A clipped accumulate never reports a bin weight
    a_sat_no_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.saturated) |-> (out_ch.bin_weight == '0))
        else $error("saturated result carries a bin weight");

    // Input is closed until the start-up sweep ends
    a_init_closed: assert property (@(posedge clk) disable iff (!rst_n)
        status.init_clear |-> !in_ch.ready)
        else $error("transfer possible during start-up sweep");

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench - masked weighted histogram peak core
// Drives pixel commands through the valid/ready input channel and checks
// every result against a bit-accurate histogram and peak tracker kept here.
// Covers directed corner cases, four idling phases with label changes, a
// long output hold-off, a drain pause, and short full-scale runs on both
// end bins.
// ============================================================================
module testbench;

    // Stimulus and timing constants
    localparam int PIX_W       = mwhp_pkg::PIXEL_WIDTH_DEF;
    localparam int BIN_LAST    = mwhp_pkg::BIN_COUNT_DEF - 1;
    localparam int PIX_MAX     = (1 << (PIX_W - 1)) - 1;
    localparam int PIX_MIN     = -(1 << (PIX_W - 1));
    localparam logic [mwhp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 135;
    localparam int END_RUN     = 5;         // full-scale adds on each end bin
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 20;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [mwhp_pkg::MODE_W-1:0]  mode;
        logic [PIX_W-1:0]             pixel_value;
        logic [mwhp_pkg::LABEL_W-1:0] seg_label;
        logic [mwhp_pkg::RBIN_W-1:0]  read_bin;
    } pixel_cmd_t;

    typedef struct packed {
        logic [mwhp_pkg::PBIN_W-1:0] peak_bin;
        logic [mwhp_pkg::PWGT_W-1:0] peak_weight;
        logic [mwhp_pkg::WGT_W-1:0]  bin_weight;
        logic                        saturated;
    } peak_report_t;

    // ------------------------------------------------------------------------
    // Histogram tracker: mirrors the bins, the peak and the target label, and
    // holds the reports still owed by the block in transfer order.
    // ------------------------------------------------------------------------
    class histogram_tracker;
        int                           bin_weights[int];
        logic [mwhp_pkg::PBIN_W-1:0]  peak_idx;
        int                           peak_val;
        logic [mwhp_pkg::LABEL_W-1:0] target_label;
        peak_report_t                 reports_due[$];
        int                           errors;

        function new();
            peak_idx     = '0;
            peak_val     = 0;
            target_label = mwhp_pkg::TARGET_LABEL_RST;
            errors       = 0;
        endfunction

        function int weight_of(int idx);
            return bin_weights.exists(idx) ? bin_weights[idx] : 0;
        endfunction

        function void flag(string msg);
            errors++;
            $error("%s", msg);
        endfunction

        function int outstanding();
            return reports_due.size();
        endfunction

        // Apply one accepted command to the mirror and queue its report
        function void note_pixel_cmd(pixel_cmd_t c);
            peak_report_t r;
            longint       v;
            longint       total;
            int           slot;
            r.bin_weight = '0;
            r.saturated  = 1'b0;
            case (c.mode)
                mwhp_pkg::MODE_ACC:
                    if (c.seg_label == target_label)
                    begin
                        v = $signed(c.pixel_value);
                        slot = (v < 0) ? 0 : (v > BIN_LAST) ? BIN_LAST : int'(v);
                        total = longint'(weight_of(slot)) + v;
                        if (total > longint'(2147483647))
                        begin
                            total       = longint'(2147483647);
                            r.saturated = 1'b1;
                        end
                        else if (total < -longint'(2147483647) - 1)
                        begin
                            total       = -longint'(2147483647) - 1;
                            r.saturated = 1'b1;
                        end
                        bin_weights[slot] = int'(total);
                        // strict compare: a tie leaves the peak where it is
                        if (int'(total) > peak_val)
                        begin
                            peak_idx = slot[mwhp_pkg::PBIN_W-1:0];
                            peak_val = int'(total);
                        end
                    end
                mwhp_pkg::MODE_READ:
                    r.bin_weight = weight_of(int'(c.read_bin));
                mwhp_pkg::MODE_CLEAR:
                begin
                    bin_weights.delete();
                    peak_idx = '0;
                    peak_val = 0;
                end
                default: ;
            endcase
            r.peak_bin    = peak_idx;
            r.peak_weight = peak_val[mwhp_pkg::PWGT_W-1:0];
            reports_due.insert(reports_due.size(), r);
        endfunction

        // Compare one result transfer with the oldest report owed
        function void check_result(peak_report_t got);
            peak_report_t exp;
            if (reports_due.size() == 0)
            begin
                flag("result transfer with no command outstanding");
                return;
            end
            exp = reports_due.pop_front();
            if (got.peak_bin !== exp.peak_bin)
                flag($sformatf("peak_bin: expected %0d, got %0d",
                               exp.peak_bin, got.peak_bin));
            if (got.peak_weight !== exp.peak_weight)
                flag($sformatf("peak_weight: expected %0d, got %0d",
                               exp.peak_weight, got.peak_weight));
            if (got.bin_weight !== exp.bin_weight)
                flag($sformatf("bin_weight: expected %0d, got %0d",
                               $signed(exp.bin_weight), $signed(got.bin_weight)));
            if (got.saturated !== exp.saturated)
                flag($sformatf("saturated: expected %0b, got %0b",
                               exp.saturated, got.saturated));
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [mwhp_pkg::LABEL_W-1:0] cfg_data;
    int                           sender_idle_pct;
    int                           receiver_stall_pct;
    bit                           holdoff_req;
    int                           cycle_count;
    histogram_tracker             tracker;

    mwhp_in_if  pix_if ();
    mwhp_out_if res_if ();

    masked_weighted_histogram_peak_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (pix_if),
        .out_ch   (res_if)
    );

    always #6 clk = ~clk;

    // Watchdog: end the run if the block stops making progress
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Observe both channels. Note the input first so that a result leaving in
    // the same cycle as its command arrives still finds its report.
    always @(posedge clk)
    begin
        pixel_cmd_t   seen;
        peak_report_t got;
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                seen.mode        = pix_if.mode;
                seen.pixel_value = pix_if.pixel_value;
                seen.seg_label   = pix_if.seg_label;
                seen.read_bin    = pix_if.read_bin;
                tracker.note_pixel_cmd(seen);
            end
            if (res_if.valid && res_if.ready)
            begin
                got.peak_bin    = res_if.peak_bin;
                got.peak_weight = res_if.peak_weight;
                got.bin_weight  = res_if.bin_weight;
                got.saturated   = res_if.saturated;
                tracker.check_result(got);
            end
        end
    end

    // Receiver: stall at the phase's rate, or hold off for a long stretch
    // when asked so that the command queue fills and the input stalls.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holdoff_req = 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    function automatic pixel_cmd_t make_cmd(logic [mwhp_pkg::MODE_W-1:0] m, int pix,
                                            int lbl, int rb);
        pixel_cmd_t c;
        c.mode        = m;
        c.pixel_value = PIX_W'(pix);
        c.seg_label   = mwhp_pkg::LABEL_W'(lbl);
        c.read_bin    = mwhp_pkg::RBIN_W'(rb);
        return c;
    endfunction

    // Mostly matching pixels clustered on a few bins so that the peak moves
    // and ties occur; reads favour those bins; the rest is noise.
    function automatic pixel_cmd_t random_pixel_cmd();
        pixel_cmd_t c;
        int         pick;
        int         pix;
        int         lbl;
        int         rb;
        pick = $urandom_range(0, 99);
        lbl  = ($urandom_range(0, 99) < 85) ? int'(tracker.target_label)
                                            : $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pix = $urandom_range(0, 31);
            4:          pix = -$urandom_range(1, 200);
            5, 6:       pix = $urandom_range(0, (1 << PIX_W) - 1);
            7:          pix = $urandom_range(mwhp_pkg::BIN_COUNT_DEF, PIX_MAX);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       pix = PIX_MAX;
                    1:       pix = PIX_MIN;
                    2:       pix = BIN_LAST;
                    default: pix = 0;
                endcase
            end
            default:    pix = $urandom_range(0, BIN_LAST);
        endcase
        case ($urandom_range(0, 3))
            0, 1:    rb = $urandom_range(0, 31);
            2:       rb = $urandom_range(0, BIN_LAST);
            default: rb = ($urandom_range(0, 1) != 0) ? BIN_LAST : 0;
        endcase
        if (pick < 64)
            c = make_cmd(mwhp_pkg::MODE_ACC, pix, lbl, $urandom_range(0, BIN_LAST));
        else if (pick < 94)
            c = make_cmd(mwhp_pkg::MODE_READ, $urandom_range(0, (1 << PIX_W) - 1),
                         $urandom_range(0, 255), rb);
        else
            c = make_cmd(MODE_UNUSED, pix, lbl, rb);
        return c;
    endfunction

    // Offer one command, idling first at the phase's rate. Called at the
    // edge where the previous transfer happened, so a back-to-back item
    // keeps valid high and only changes the payload.
    task automatic send_item(pixel_cmd_t c);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.mode        <= c.mode;
        pix_if.pixel_value <= c.pixel_value;
        pix_if.seg_label   <= c.seg_label;
        pix_if.read_bin    <= c.read_bin;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every owed result has arrived; first let the
    // monitor note the last transfer
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_label(logic [mwhp_pkg::LABEL_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tracker.target_label = value;
    endtask

    initial
    begin
        logic [mwhp_pkg::LABEL_W-1:0] phase_label [4];
        int                           clear_at;
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = '0;
        pix_if.valid       = 1'b0;
        pix_if.mode        = mwhp_pkg::MODE_ACC;
        pix_if.pixel_value = '0;
        pix_if.seg_label   = '0;
        pix_if.read_bin    = '0;
        res_if.ready       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_req        = 1'b0;
        tracker            = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the label still at its reset value
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 0, 1, 0));        // zero add, no peak move
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 5, 1, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 10, 1, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 5, 1, 0));        // tie with the peak
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 10, 2, 0));       // label mismatch
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 10, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 10, 255, BIN_LAST));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, PIX_MAX, 1, 0));  // clamps to the last bin
        send_item(make_cmd(mwhp_pkg::MODE_ACC, PIX_MIN, 1, 0));  // negative into bin 0
        send_item(make_cmd(mwhp_pkg::MODE_ACC, -1, 1, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, BIN_LAST, 1, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, mwhp_pkg::BIN_COUNT_DEF, 1, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, 5));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, BIN_LAST));
        send_item(make_cmd(mwhp_pkg::MODE_READ, -1, 255, 12345)); // never written: zero
        send_item(make_cmd(MODE_UNUSED, PIX_MAX, 1, BIN_LAST));
        send_item(make_cmd(mwhp_pkg::MODE_CLEAR, PIX_MIN, 255, 21845));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, BIN_LAST));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 7, 1, 0));
        wait_drained();

        // Random phases: each with its own idling, label and one clear
        phase_label[0] = 8'd0;
        phase_label[1] = 8'd255;
        phase_label[2] = mwhp_pkg::LABEL_W'($urandom_range(2, 254));
        phase_label[3] = mwhp_pkg::LABEL_W'($urandom_range(0, 255));
        for (int phase = 0; phase < 4; phase++)
        begin
            write_label(phase_label[phase]);
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 74; receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 74;
                end
                default:
                begin
                    sender_idle_pct = 32; receiver_stall_pct = 32;
                end
            endcase
            clear_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 0 && i == 20)
                    holdoff_req = 1'b1;                    // fill the queue
                if (phase == 3 && i == 60)
                    wait_drained();                        // pause until empty
                if (i == clear_at)
                    send_item(make_cmd(mwhp_pkg::MODE_CLEAR,
                                       $urandom_range(0, (1 << PIX_W) - 1),
                                       $urandom_range(0, 255), $urandom_range(0, BIN_LAST)));
                else
                    send_item(random_pixel_cmd());
            end
            wait_drained();
        end

        // Short full-rate runs of full-scale adds on the last bin and bin 0
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_label(mwhp_pkg::TARGET_LABEL_RST);
        for (int i = 0; i < END_RUN; i++)
            send_item(make_cmd(mwhp_pkg::MODE_ACC, PIX_MAX, mwhp_pkg::TARGET_LABEL_RST, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, BIN_LAST));
        for (int i = 0; i < END_RUN; i++)
            send_item(make_cmd(mwhp_pkg::MODE_ACC, PIX_MIN, mwhp_pkg::TARGET_LABEL_RST, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_ACC, 1, mwhp_pkg::TARGET_LABEL_RST, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, BIN_LAST));
        send_item(make_cmd(mwhp_pkg::MODE_CLEAR, 0, 0, 0));
        send_item(make_cmd(mwhp_pkg::MODE_READ, 0, 0, BIN_LAST));

        // Drain, allow for late stray results, then report
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (tracker.outstanding() != 0)
            tracker.flag("commands left without a result");
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
